// File: rtl/mkpq_pkg.sv
package mkpq_pkg;

  // Default sizing of the queue.
  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 16;

  // Fixed port widths of the transaction fields.
  localparam int KEY_PORT_W = 16;
  localparam int PAYLOAD_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;

  // Function codes of an input transaction.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast from the control logic to every slot.
  typedef struct packed {
    logic                  enq;
    logic                  deq;
    logic [KEY_PORT_W-1:0] key;
    logic [PAYLOAD_W-1:0]  payload;
  } cell_cmd_t;

endpackage

// File: rtl/mkpq_cell.sv
module mkpq_cell import mkpq_pkg::*; #(
  parameter int KW = DEF_KEY_BITS
) (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic                 occupied,
  input  logic                 left_le,
  input  logic [KW-1:0]        left_key,
  input  logic [PAYLOAD_W-1:0] left_payload,
  input  logic [KW-1:0]        right_key,
  input  logic [PAYLOAD_W-1:0] right_payload,
  output logic                 le,
  output logic [KW-1:0]        entry_key,
  output logic [PAYLOAD_W-1:0] entry_payload
);

  // A held entry whose key is not above the new key stays in front of it.
  assign le = occupied && (entry_key <= cmd.key[KW-1:0]);

  // Keep, take the new entry, shift toward the tail, or shift toward the head.
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (!le) begin
        if (left_le) begin
          entry_key     <= cmd.key[KW-1:0];
          entry_payload <= cmd.payload;
        end else begin
          entry_key     <= left_key;
          entry_payload <= left_payload;
        end
      end
    end else if (cmd.deq) begin
      entry_key     <= right_key;
      entry_payload <= right_payload;
    end
  end

endmodule

// File: rtl/min_key_priority_queue.sv
// A transaction accepted at a clock edge is held in the input register; the
// result register then raises its result strobe (done).
// Throughput: one transaction per cycle; busy is never raised, since the slot
// array updates all slots in parallel in the cycle after the input register.
// Reset (synchronous, rst high) empties the queue and clears the done strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module min_key_priority_queue import mkpq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [KEY_PORT_W-1:0] key,
  input  logic [PAYLOAD_W-1:0]  payload,
  output logic                  done,
  output logic                  out_valid,
  output logic [KEY_PORT_W-1:0] out_key,
  output logic [PAYLOAD_W-1:0]  out_payload,
  output logic [STATUS_W-1:0]   status,
  output logic [OCC_W-1:0]      occupancy
);

  // Only the low bits of the key port reach storage.
  localparam int KW    = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  in_vld;
  logic                  in_func;
  logic [KEY_PORT_W-1:0] in_key;
  logic [PAYLOAD_W-1:0]  in_payload;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  full;
  logic                  empty;
  cell_cmd_t             cmd;
  status_t               st_next;

  logic [CAPACITY-1:0]   occ;
  logic [CAPACITY-1:0]   le;
  logic [KW-1:0]         slot_key     [CAPACITY];
  logic [PAYLOAD_W-1:0]  slot_payload [CAPACITY];

  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    in_func    <= func;
    in_key     <= key;
    in_payload <= payload;
  end

  // Decode of the registered transaction against the current fill level.
  always_comb begin
    full        = (count == CNT_W'(CAPACITY));
    empty       = (count == '0);
    cmd.enq     = in_vld && (in_func == FUNC_ENQ) && !full;
    cmd.deq     = in_vld && (in_func == FUNC_DEQ) && !empty;
    cmd.key     = in_key & KEY_PORT_W'((64'd1 << KW) - 64'd1);
    cmd.payload = in_payload;
    count_next  = count;
    st_next     = ST_OK;
    if (cmd.enq) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.deq) begin
      count_next = count - CNT_W'(1);
    end
    if (in_vld && (in_func == FUNC_ENQ) && full) begin
      st_next = ST_FULL;
    end else if (in_vld && (in_func == FUNC_DEQ) && empty) begin
      st_next = ST_EMPTY;
    end
  end

  // Sorted slot array, slot 0 at the head. The head slot has nothing in
  // front of it, so it takes the new entry whenever its own entry moves back.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign occ[i] = (CNT_W'(i) < count);
    mkpq_cell #(
      .KW(KW)
    ) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .occupied      (occ[i]),
      .left_le       ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
      .left_key      (slot_key[(i == 0) ? 0 : i - 1]),
      .left_payload  (slot_payload[(i == 0) ? 0 : i - 1]),
      .right_key     (slot_key[(i == CAPACITY - 1) ? i : i + 1]),
      .right_payload (slot_payload[(i == CAPACITY - 1) ? i : i + 1]),
      .le            (le[i]),
      .entry_key     (slot_key[i]),
      .entry_payload (slot_payload[i])
    );
  end

  // Fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= in_vld;
    end
    out_valid   <= cmd.deq;
    out_key     <= cmd.deq ? KEY_PORT_W'(slot_key[0]) : '0;
    out_payload <= cmd.deq ? slot_payload[0] : '0;
    status      <= st_next;
    occupancy   <= OCC_W'(count_next);
  end

endmodule

// File: rtl/mkpq_checker.sv
module mkpq_checker import mkpq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  out_valid,
  input logic [KEY_PORT_W-1:0] out_key,
  input logic [PAYLOAD_W-1:0]  out_payload,
  input logic [STATUS_W-1:0]   status,
  input logic [OCC_W-1:0]      occupancy
);

  // Every accepted transaction produces its strobe through the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction produced no result");

  // No strobe appears without an accepted transaction behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a transaction");

  // A returned entry always reports ok.
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (done && out_valid) |-> (status == ST_OK))
    else $error("returned entry with error status");

  // Without a returned entry the entry fields are zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !out_valid) |-> (out_key == '0 && out_payload == '0))
    else $error("entry fields not zero");

  // A dequeue on an empty queue leaves it empty.
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with nonzero occupancy");

endmodule

bind min_key_priority_queue mkpq_checker u_mkpq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .out_valid   (out_valid),
  .out_key     (out_key),
  .out_payload (out_payload),
  .status      (status),
  .occupancy   (occupancy)
);
